// ===== rtl/rass_pkg.sv =====
package rass_pkg;

    // default tree capacity in leaves
    localparam int DEF_MAX_LEAVES = 1024;

    // point count after reset
    localparam logic [10:0] DEF_POINT_COUNT = 11'd1024;

    // register byte address of point_count
    localparam logic [1:0] ADDR_POINT_COUNT = 2'd0;

    // width of the clamped cost and of the quotients taken from it
    localparam int NUM_W = 63;

    // width of the sub-range count k(k+1)/2 for k up to 2046
    localparam int PAIR_W = 21;

    // control sequence of the block
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_UDRAIN,
        ST_QRY,
        ST_QDRAIN,
        ST_DIV_MOD,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_RESULT
    } t_state;

endpackage

// ===== rtl/rass_div.sv =====
module rass_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rass_pkg::NUM_W-1:0]    i_dividend,
    input  logic [rass_pkg::PAIR_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [rass_pkg::NUM_W-1:0]    o_quot,
    output logic [rass_pkg::PAIR_W-1:0]   o_rem
);

    localparam int NW = rass_pkg::NUM_W;
    localparam int PW = rass_pkg::PAIR_W;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

    logic [NW-1:0] r_quot;
    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [PW:0]   trial;
    logic          fits;
    logic [PW-1:0] n_rem;

    // one restoring step: bring down the next dividend bit and try the divisor
    always_comb begin
        trial = {r_rem, r_quot[NW-1]};
        fits  = (trial >= {1'b0, r_div});
        if (fits) begin
            n_rem = PW'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[PW-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[NW-2:0], fits};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/range_add_subsegment_sum_tree.sv =====
// Range add and sub-range average on edges 1 .. point_count-1 (<MAX_LEAVES).
// Input channel (i_in_valid / o_in_stall): action 0 adds value to edges
// left .. right-1 and gives no result; action 1 returns the average sum over
// all sub-ranges of edges left .. right-1 as a reduced fraction.
// Output channel (o_out_valid / i_out_stall): one beat per query, held in an
// output register while stalled; the next item is taken meanwhile, but a
// further query result waits until that register is free.
// An update does one memory read-modify-write per edge. A query builds the
// weighted sum through the edge memory, then runs one pass of the 63-step
// serial divider, a binary gcd and two more divider passes. An empty range
// skips the memory and the divider.
// The point_count register lives at byte address 0 of the APB port, though
// a write at any address sets it. Writing it, and reset, starts a clearing
// pass over every word of the edge memory during which o_in_stall stays high.
module range_add_subsegment_sum_tree #(
    parameter int MAX_LEAVES = rass_pkg::DEF_MAX_LEAVES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [9:0]         i_left,
    input  logic [10:0]        i_right,
    input  logic signed [15:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [62:0]        o_numerator,
    output logic [18:0]        o_denominator
);

    localparam int NW = rass_pkg::NUM_W;
    localparam int PW = rass_pkg::PAIR_W;
    localparam int AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
    localparam logic [10:0] EDGE_LIM = (MAX_LEAVES > 2047) ? 11'd2047 : 11'(MAX_LEAVES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_LEAVES - 1);

    rass_pkg::t_state r_state, n_state;

    logic [10:0]   r_point_count;
    logic [AW-1:0] r_clr;

    logic [10:0]   r_lo, r_hi, r_idx;
    logic [63:0]   r_x;
    logic [PW-1:0] r_pairs;

    logic [63:0]   r_mem [MAX_LEAVES];
    logic [63:0]   r_rdata;
    logic          r_uv;
    logic [10:0]   r_uaddr;

    logic          r_qv0, r_qv1;
    logic [21:0]   r_w;
    logic [53:0]   r_p0;
    logic [31:0]   r_p1;
    logic [63:0]   r_acc;

    logic [NW-1:0] r_cost;
    logic [PW-1:0] r_ga, r_gb, r_g;
    logic [4:0]    r_sh;
    logic [NW-1:0] r_num;
    logic [PW-1:0] r_den;

    logic          r_out_valid;
    logic [62:0]   r_out_num;
    logic [18:0]   r_out_den;

    logic          cfg_we;
    logic          accept;
    logic [10:0]   eff_pc, lo, hi, kk;
    logic          is_empty;
    logic [21:0]   pairs_full;
    logic [10:0]   wl, wr;
    logic [21:0]   w;
    logic [NW-1:0] cost_clamped;
    logic [PW-1:0] gcd_val;
    logic          last_idx;
    logic          out_free;

    logic          rd_en;
    logic          div_start;
    logic [NW-1:0] div_dividend;
    logic [PW-1:0] div_divisor;
    logic          div_done;
    logic [NW-1:0] div_quot;
    logic [PW-1:0] div_rem;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr == rass_pkg::ADDR_POINT_COUNT) ? {21'b0, r_point_count} : 32'b0;

    // range decode of the incoming beat
    always_comb begin
        eff_pc     = (r_point_count < EDGE_LIM) ? r_point_count : EDGE_LIM;
        lo         = (i_left == 10'd0) ? 11'd1 : {1'b0, i_left};
        hi         = (i_right < eff_pc) ? i_right : eff_pc;
        is_empty   = (lo >= hi);
        kk         = hi - lo;
        pairs_full = 22'(kk) * 22'(kk + 11'd1);
    end

    assign accept     = i_in_valid && (r_state == rass_pkg::ST_IDLE);
    assign o_in_stall = (r_state != rass_pkg::ST_IDLE);

    // weight of edge i: sub-ranges that contain it
    always_comb begin
        wl = r_idx - r_lo + 11'd1;
        wr = r_hi - r_idx;
        w  = 22'(wl) * 22'(wr);
    end

    assign cost_clamped = r_acc[63] ? '0 : r_acc[62:0];
    assign gcd_val      = PW'(((r_ga == '0) ? r_gb : r_ga) << r_sh);
    assign last_idx     = (r_idx == r_hi - 11'd1);
    assign out_free     = !r_out_valid || !i_out_stall;

    // next state and strobes
    always_comb begin
        n_state      = r_state;
        rd_en        = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            rass_pkg::ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = rass_pkg::ST_IDLE;
                end
            end
            rass_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (is_empty) begin
                        n_state = i_action ? rass_pkg::ST_RESULT : rass_pkg::ST_IDLE;
                    end else begin
                        n_state = i_action ? rass_pkg::ST_QRY : rass_pkg::ST_UPD;
                    end
                end
            end
            rass_pkg::ST_UPD: begin
                rd_en = 1'b1;
                if (last_idx) begin
                    n_state = rass_pkg::ST_UDRAIN;
                end
            end
            rass_pkg::ST_UDRAIN: begin
                n_state = rass_pkg::ST_IDLE;
            end
            rass_pkg::ST_QRY: begin
                rd_en = 1'b1;
                if (last_idx) begin
                    n_state = rass_pkg::ST_QDRAIN;
                end
            end
            rass_pkg::ST_QDRAIN: begin
                if (!r_qv0 && !r_qv1) begin
                    div_start    = 1'b1;
                    div_dividend = cost_clamped;
                    div_divisor  = r_pairs;
                    n_state      = rass_pkg::ST_DIV_MOD;
                end
            end
            rass_pkg::ST_DIV_MOD: begin
                if (div_done) begin
                    n_state = rass_pkg::ST_GCD;
                end
            end
            rass_pkg::ST_GCD: begin
                if (r_ga == '0 || r_gb == '0) begin
                    div_start    = 1'b1;
                    div_dividend = r_cost;
                    div_divisor  = gcd_val;
                    n_state      = rass_pkg::ST_DIV_NUM;
                end
            end
            rass_pkg::ST_DIV_NUM: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = NW'(r_pairs);
                    div_divisor  = r_g;
                    n_state      = rass_pkg::ST_DIV_DEN;
                end
            end
            rass_pkg::ST_DIV_DEN: begin
                if (div_done) begin
                    n_state = rass_pkg::ST_RESULT;
                end
            end
            rass_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = rass_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rass_pkg::ST_IDLE;
            end
        endcase
        if (cfg_we) begin
            n_state = rass_pkg::ST_CLEAR;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rass_pkg::ST_CLEAR;
            r_point_count <= rass_pkg::DEF_POINT_COUNT;
            r_clr         <= '0;
            r_uv          <= 1'b0;
            r_qv0         <= 1'b0;
            r_qv1         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                r_point_count <= pwdata[10:0];
                r_clr         <= '0;
            end else if (r_state == rass_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_uv  <= (r_state == rass_pkg::ST_UPD);
            r_qv0 <= (r_state == rass_pkg::ST_QRY);
            r_qv1 <= r_qv0;
            if (r_state == rass_pkg::ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item registers, weighted sum pipeline and gcd
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo    <= lo;
            r_hi    <= hi;
            r_idx   <= lo;
            r_x     <= {{48{i_value[15]}}, i_value};
            r_pairs <= pairs_full[PW:1];
            r_acc   <= '0;
            r_num   <= '0;
            r_den   <= PW'(1);
        end else if (rd_en) begin
            r_idx <= r_idx + 11'd1;
        end
        r_uaddr <= r_idx;
        r_w     <= w;
        r_p0    <= 54'(r_rdata[31:0]) * 54'(r_w);
        r_p1    <= 32'(54'(r_rdata[63:32]) * 54'(r_w));
        if (r_qv1) begin
            r_acc <= r_acc + 64'(r_p0) + {r_p1, 32'b0};
        end
        if (r_state == rass_pkg::ST_QDRAIN) begin
            r_cost <= cost_clamped;
        end
        // binary gcd of the pair count and the cost remainder
        if (r_state == rass_pkg::ST_DIV_MOD && div_done) begin
            r_ga <= r_pairs;
            r_gb <= div_rem;
            r_sh <= '0;
        end else if (r_state == rass_pkg::ST_GCD) begin
            if (r_ga == '0 || r_gb == '0) begin
                r_g <= gcd_val;
            end else if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_sh <= r_sh + 5'd1;
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (r_state == rass_pkg::ST_DIV_NUM && div_done) begin
            r_num <= div_quot;
        end
        if (r_state == rass_pkg::ST_DIV_DEN && div_done) begin
            r_den <= div_quot[PW-1:0];
        end
        if (r_state == rass_pkg::ST_RESULT && out_free) begin
            r_out_num <= r_num;
            r_out_den <= r_den[18:0];
        end
    end

    // edge memory write port: clearing pass or update write-back
    always_comb begin
        mem_we = (r_state == rass_pkg::ST_CLEAR) || r_uv;
        if (r_state == rass_pkg::ST_CLEAR) begin
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_waddr = AW'(r_uaddr);
            mem_wdata = r_rdata + r_x;
        end
    end

    // edge memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[AW'(r_idx)];
        end
    end

    rass_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_out_valid   = r_out_valid;
    assign o_numerator   = r_out_num;
    assign o_denominator = r_out_den;

endmodule

// ===== bench/subrange_sum_checker.sv =====
module subrange_sum_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_action,
    input  logic [9:0]         i_left,
    input  logic [10:0]        i_right,
    input  logic signed [15:0] i_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [62:0]        i_numerator,
    input  logic [18:0]        i_denominator,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [62:0] numerator;
        logic [18:0] denominator;
    } t_average;

    logic [63:0] edge_sum [1:1023];
    logic [10:0] points;
    t_average    averages_due [$];

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // apply one accepted beat to the edge row, queue the average for a query
    task automatic apply_item(logic act, logic [9:0] lft, logic [10:0] rgt,
                              logic signed [15:0] val);
        int unsigned eff, lo, hi, k;
        logic [63:0] addend, cost, pairs, g;
        t_average    avg;
        eff = (points > 1024) ? 1024 : points;
        lo = (lft < 1) ? 1 : lft;
        hi = (rgt < eff) ? rgt : eff;
        addend = {{48{val[15]}}, val};
        avg.numerator = '0;
        avg.denominator = 19'd1;
        if (eff >= 2 && lo < hi) begin
            if (act == 1'b0) begin
                for (int i = lo; i < hi; i++) edge_sum[i] += addend;
            end else begin
                // each edge sits in (i-lo+1)*(hi-i) sub-ranges
                cost = '0;
                for (int i = lo; i < hi; i++)
                    cost += edge_sum[i] * 64'(i - lo + 1) * 64'(hi - i);
                k = hi - lo;
                pairs = 64'(k) * 64'(k + 1) / 2;
                if (cost[63]) cost = '0;
                g = gcd64(cost, pairs);
                avg.numerator = 63'(cost / g);
                avg.denominator = 19'(pairs / g);
            end
        end
        if (act == 1'b1) averages_due.push_back(avg);
    endtask

    always @(posedge i_clk) begin
        t_average want;
        if (!i_rst_n) begin
            points <= rass_pkg::DEF_POINT_COUNT;
            for (int i = 1; i < 1024; i++) edge_sum[i] = '0;
            averages_due.delete();
            o_errors <= 0;
        end else begin
            // register write clears the row
            if (psel && penable && pwrite && pready
                && paddr == rass_pkg::ADDR_POINT_COUNT) begin
                points <= pwdata[10:0];
                for (int i = 1; i < 1024; i++) edge_sum[i] = '0;
            end
            if (i_in_valid && !i_in_stall)
                apply_item(i_action, i_left, i_right, i_value);
            // result beat
            if (i_out_valid && !i_out_stall) begin
                if (averages_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result beat %0d/%0d", i_numerator,
                                 i_denominator);
                    o_errors <= o_errors + 1;
                end else begin
                    want = averages_due.pop_front();
                    if (want.numerator !== i_numerator
                        || want.denominator !== i_denominator) begin
                        if (o_errors < 10)
                            $display("average mismatch: expected %0d/%0d got %0d/%0d",
                                     want.numerator, want.denominator,
                                     i_numerator, i_denominator);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= averages_due.size();
    end
endmodule

// ===== bench/tb_range_add_subsegment_sum_tree.sv =====
module tb_range_add_subsegment_sum_tree;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE = 1300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = 1'b0;
    logic [9:0]         i_left = '0;
    logic [10:0]        i_right = '0;
    logic signed [15:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [62:0]        o_numerator;
    logic [18:0]        o_denominator;
    int                 errors;
    int                 pending;
    int unsigned        cycles = 0;

    range_add_subsegment_sum_tree u_top (.*);

    subrange_sum_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_action, .i_left, .i_right,
        .i_value, .i_out_valid(o_out_valid), .i_out_stall, .i_numerator(o_numerator),
        .i_denominator(o_denominator), .o_errors(errors), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int unsigned rx_cycles;
        int unsigned mode;
        rx_cycles = 0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (rx_cycles % 500 == 0) mode = $urandom_range(0, 3);
            if (rx_cycles > 20000 && rx_cycles < 26000) i_out_stall <= 1'b1;
            else if (mode == 0) i_out_stall <= 1'b0;
            else if (mode == 1) i_out_stall <= ($urandom_range(0, 3) == 0);
            else i_out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    task automatic write_points(logic [10:0] count);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rass_pkg::ADDR_POINT_COUNT;
        pwdata <= {21'd0, count};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // offer one beat and hold it until taken
    task automatic send_item(logic act, logic [9:0] lft, logic [10:0] rgt,
                             logic signed [15:0] val);
        i_in_valid <= 1'b1;
        i_action <= act;
        i_left <= lft;
        i_right <= rgt;
        i_value <= val;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // let the checker see the last beat before waiting on its count
    task automatic drain_results();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_items(int count);
        int unsigned lft, rgt, shape, burst;
        logic signed [15:0] val;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(0, 19);
            lft = $urandom_range(0, 1023);
            if (shape == 0) rgt = $urandom_range(0, 2047);
            else if (shape == 1) begin
                lft = $urandom_range(0, 3);
                rgt = $urandom_range(1000, 2047);
            end else rgt = lft + $urandom_range(0, 16);
            val = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 400));
            send_item($urandom_range(0, 1), 10'(lft), 11'(rgt), val);
            // bursts with random gaps
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
                end
            end else burst--;
        end
    endtask

    initial begin
        logic [10:0] settings [7];
        settings = '{11'd2, 11'd0, 11'd1, 11'd2047, 11'd17, 11'd1024, 11'd600};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both actions, empty and clamped ranges
        send_item(1'b1, 10'd0, 11'd2047, 16'sd0);
        send_item(1'b0, 10'd0, 11'd2047, 16'sd32767);
        send_item(1'b1, 10'd0, 11'd2047, 16'sd0);
        send_item(1'b1, 10'd1023, 11'd1024, 16'sd0);
        send_item(1'b1, 10'd1023, 11'd2047, 16'sd0);
        send_item(1'b0, 10'd5, 11'd5, 16'sd100);
        send_item(1'b1, 10'd5, 11'd5, 16'sd0);
        send_item(1'b1, 10'd9, 11'd3, 16'sd0);
        send_item(1'b0, 10'd10, 11'd20, -16'sd32768);
        send_item(1'b0, 10'd10, 11'd20, -16'sd32768);
        send_item(1'b1, 10'd1, 11'd40, 16'sd0);
        send_item(1'b1, 10'd12, 11'd15, 16'sd0);
        send_item(1'b0, 10'd1, 11'd1024, -16'sd1);
        send_item(1'b1, 10'd1, 11'd1024, 16'sd0);
        send_item(1'b1, 10'd682, 11'd1365, 16'sd0);
        send_item(1'b0, 10'd1, 11'd2, 16'sd7);
        send_item(1'b1, 10'd1, 11'd2, 16'sd0);
        random_items(200);
        drain_results();

        foreach (settings[s]) begin
            write_points(settings[s]);
            random_items(190);
            send_item(1'b1, 10'd0, 11'd2047, 16'sd0);
            drain_results();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
